@@ hw/rtl/stl_pkg.sv @@
// Shared types, codes and character classification functions for the script token lexer.
package stl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_WORD = 3'd1,
    MODE_INT  = 3'd2,
    MODE_REAL = 3'd3,
    MODE_STR  = 3'd4,
    MODE_SYM  = 3'd5,
    MODE_DEAD = 3'd6
  } mode_t;

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_BOOL    = 3'd1;
  localparam logic [2:0] KIND_IDENT   = 3'd2;
  localparam logic [2:0] KIND_INT     = 3'd3;
  localparam logic [2:0] KIND_REAL    = 3'd4;
  localparam logic [2:0] KIND_STRING  = 3'd5;
  localparam logic [2:0] KIND_SYMBOL  = 3'd6;
  localparam logic [2:0] KIND_ERROR   = 3'd7;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [5:0]  detail;
    logic        last;
  } tok_t;

  // Up to two tokens handed from the front part to the queue per item.
  typedef struct packed {
    logic valid0;
    logic valid1;
    tok_t tok0;
    tok_t tok1;
  } push_t;

  localparam logic [63:0] KW_VAR      = 64'("var");
  localparam logic [63:0] KW_IF       = 64'("if");
  localparam logic [63:0] KW_THEN     = 64'("then");
  localparam logic [63:0] KW_ELSE     = 64'("else");
  localparam logic [63:0] KW_FOR      = 64'("for");
  localparam logic [63:0] KW_WHILE    = 64'("while");
  localparam logic [63:0] KW_DO       = 64'("do");
  localparam logic [63:0] KW_IN       = 64'("in");
  localparam logic [63:0] KW_FUNCTION = 64'("function");
  localparam logic [63:0] KW_RETURN   = 64'("return");
  localparam logic [63:0] KW_TRUE     = 64'("true");
  localparam logic [63:0] KW_FALSE    = 64'("false");

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_idc(input logic [7:0] b);
    return is_digit(b) || is_alpha(b) || b == "_";
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    return b == 8'h22 || b == 8'h27;
  endfunction

  // Single-character symbol: returns valid flag above a 6-bit code.
  function automatic logic [6:0] single_code(input logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    unique case (b)
      "{": r = {1'b1, 6'd0};
      "}": r = {1'b1, 6'd1};
      "(": r = {1'b1, 6'd2};
      ")": r = {1'b1, 6'd3};
      "[": r = {1'b1, 6'd4};
      "]": r = {1'b1, 6'd5};
      "<": r = {1'b1, 6'd6};
      ">": r = {1'b1, 6'd7};
      "+": r = {1'b1, 6'd8};
      "-": r = {1'b1, 6'd9};
      "*": r = {1'b1, 6'd10};
      "/": r = {1'b1, 6'd11};
      "%": r = {1'b1, 6'd12};
      "!": r = {1'b1, 6'd13};
      "?": r = {1'b1, 6'd14};
      "=": r = {1'b1, 6'd15};
      ".": r = {1'b1, 6'd16};
      ",": r = {1'b1, 6'd17};
      "&": r = {1'b1, 6'd18};
      "|": r = {1'b1, 6'd19};
      ";": r = {1'b1, 6'd20};
      ":": r = {1'b1, 6'd21};
      "$": r = {1'b1, 6'd22};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic may_pair(input logic [7:0] a);
    return a == "=" || a == "!" || a == ">" || a == "<" || a == "+" || a == "-" ||
           a == "*" || a == "/" || a == "%" || a == "]";
  endfunction

  // Two-character operator: valid flag above a 6-bit code.
  function automatic logic [6:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] r;
    r = 7'd0;
    if (b == "=") begin
      priority case (a)
        "=": r = {1'b1, 6'd23};
        "!": r = {1'b1, 6'd24};
        ">": r = {1'b1, 6'd25};
        "<": r = {1'b1, 6'd26};
        "+": r = {1'b1, 6'd27};
        "-": r = {1'b1, 6'd28};
        "*": r = {1'b1, 6'd29};
        "/": r = {1'b1, 6'd30};
        "%": r = {1'b1, 6'd31};
        default: r = 7'd0;
      endcase
    end else if (a == "<" && b == "[") begin
      r = {1'b1, 6'd32};
    end else if (a == "]" && b == ">") begin
      r = {1'b1, 6'd33};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/script_token_lexer.sv @@
// Top level of the script token lexer: front part, token queue and ports.
//
// The block takes source text one item per cycle on the in_ channel: a byte
// and a flag that marks the final byte of a text. Each accepted byte may
// finish zero, one or two tokens; each token leaves as one item on the out_
// channel with its kind, start offset, length, detail code and a flag on the
// final token caused by that byte.
// An item is accepted on a rising edge where valid is high and stall is low.
// The front part handles every byte combinationally, so a token enters the queue
// at the clock edge where the byte that finishes it is accepted.
// Tokens wait in a four-entry queue; a byte is accepted whenever the queue has
// room for two tokens, so the block takes one byte per cycle while the output
// side keeps up, and the output drains one token per cycle while out_stall is low.
// When the receiver stalls, tokens pile up in the queue and in_stall rises
// once fewer than two entries are free; nothing is lost or repeated.
// Reset (rst_n low at a clock edge) empties the queue and returns the lexer
// to idle at offset zero; queued payloads are simply discarded.
// Offsets and lengths count up to 2^OFFSET_BITS-1 and appear clamped to
// 16 bits on the ports. After an invalid byte the rest of the text is
// skipped until the end-of-text flag.
module script_token_lexer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [5:0]  out_detail_code,
  output logic        out_last_of_run
);
  import stl_pkg::*;

  push_t push;
  tok_t  head;
  logic  full;
  logic  accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  stl_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .push        (push)
  );

  stl_token_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.len;
  assign out_detail_code  = head.detail;
  assign out_last_of_run  = head.last;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("offered token withdrawn");
  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !accept) else $error("byte accepted while full");
  a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == KIND_ERROR) |-> out_token_length == 16'd1)
    else $error("error token length");

endmodule

@@ hw/rtl/stl_front.sv @@
// Front part of the lexer: per-byte classification, token state and token formation.
module stl_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     text_byte,
  input  logic           end_of_text,
  output stl_pkg::push_t push
);
  import stl_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

  mode_t                  mode_r, mode_nxt;
  logic                   quote_single_r, quote_single_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [OFFSET_BITS-1:0] len_r, len_nxt;
  logic [63:0]            prefix_r, prefix_nxt;
  logic [7:0]             pend_r, pend_nxt;

  tok_t ta, tb, tc;
  logic va, vb, vc, used;
  logic [6:0] sc, pc;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OFS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] clamp16(input logic [OFFSET_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tok_t mk(input logic [2:0] kind, input logic [OFFSET_BITS-1:0] st,
                              input logic [OFFSET_BITS-1:0] ln, input logic [5:0] det);
    tok_t t;
    t.kind   = kind;
    t.start  = clamp16(st);
    t.len    = clamp16(ln);
    t.detail = det;
    t.last   = 1'b0;
    return t;
  endfunction

  // Finished word: keyword, bool literal or identifier.
  function automatic tok_t word_tok(input logic [63:0] p, input logic [OFFSET_BITS-1:0] ln,
                                    input logic [OFFSET_BITS-1:0] st);
    logic [31:0] l;
    tok_t t;
    l = 32'(ln);
    t = mk(KIND_IDENT, st, ln, 6'd0);
    if (l <= 32'd8) begin
      priority if (l == 32'd3 && p == KW_VAR)      t = mk(KIND_KEYWORD, st, ln, 6'd0);
      else if (l == 32'd2 && p == KW_IF)           t = mk(KIND_KEYWORD, st, ln, 6'd1);
      else if (l == 32'd4 && p == KW_THEN)         t = mk(KIND_KEYWORD, st, ln, 6'd2);
      else if (l == 32'd4 && p == KW_ELSE)         t = mk(KIND_KEYWORD, st, ln, 6'd3);
      else if (l == 32'd3 && p == KW_FOR)          t = mk(KIND_KEYWORD, st, ln, 6'd4);
      else if (l == 32'd5 && p == KW_WHILE)        t = mk(KIND_KEYWORD, st, ln, 6'd5);
      else if (l == 32'd2 && p == KW_DO)           t = mk(KIND_KEYWORD, st, ln, 6'd6);
      else if (l == 32'd2 && p == KW_IN)           t = mk(KIND_KEYWORD, st, ln, 6'd7);
      else if (l == 32'd8 && p == KW_FUNCTION)     t = mk(KIND_KEYWORD, st, ln, 6'd8);
      else if (l == 32'd6 && p == KW_RETURN)       t = mk(KIND_KEYWORD, st, ln, 6'd9);
      else if (l == 32'd4 && p == KW_TRUE)         t = mk(KIND_BOOL, st, ln, 6'd1);
      else if (l == 32'd5 && p == KW_FALSE)        t = mk(KIND_BOOL, st, ln, 6'd0);
      else                                         t = mk(KIND_IDENT, st, ln, 6'd0);
    end
    return t;
  endfunction

  always_comb begin
    mode_nxt         = mode_r;
    quote_single_nxt = quote_single_r;
    pos_nxt          = pos_r;
    start_nxt        = start_r;
    len_nxt          = len_r;
    prefix_nxt       = prefix_r;
    pend_nxt         = pend_r;
    ta = '0; tb = '0; tc = '0;
    va = 1'b0; vb = 1'b0; vc = 1'b0;
    used = 1'b1;
    sc = single_code(text_byte);
    pc = pair_code(pend_r, text_byte);

    // Continue the token in progress.
    unique case (mode_r)
      MODE_DEAD: ;
      MODE_STR: begin
        if (text_byte == (quote_single_r ? 8'h27 : 8'h22)) begin
          ta = mk(KIND_STRING, start_r, len_r, 6'd0); va = 1'b1;
          mode_nxt = MODE_IDLE;
        end else begin
          len_nxt = sat_inc(len_r);
        end
      end
      MODE_WORD: begin
        if (is_idc(text_byte)) begin
          if (32'(len_r) < 32'd8) prefix_nxt = {prefix_r[55:0], text_byte};
          len_nxt = sat_inc(len_r);
        end else begin
          ta = word_tok(prefix_r, len_r, start_r); va = 1'b1;
          mode_nxt = MODE_IDLE; used = 1'b0;
        end
      end
      MODE_INT: begin
        if (is_digit(text_byte)) begin
          len_nxt = sat_inc(len_r);
        end else if (text_byte == ".") begin
          len_nxt = sat_inc(len_r); mode_nxt = MODE_REAL;
        end else begin
          ta = mk(KIND_INT, start_r, len_r, 6'd0); va = 1'b1;
          mode_nxt = MODE_IDLE; used = 1'b0;
        end
      end
      MODE_REAL: begin
        if (is_digit(text_byte)) begin
          len_nxt = sat_inc(len_r);
        end else begin
          ta = mk(KIND_REAL, start_r, len_r, 6'd0); va = 1'b1;
          mode_nxt = MODE_IDLE; used = 1'b0;
        end
      end
      MODE_SYM: begin
        if (pc[6]) begin
          ta = mk(KIND_SYMBOL, start_r, OFFSET_BITS'(2), pc[5:0]); va = 1'b1;
        end else begin
          ta = mk(KIND_SYMBOL, start_r, OFFSET_BITS'(1), 6'(single_code(pend_r)));
          va = 1'b1; used = 1'b0;
        end
        mode_nxt = MODE_IDLE;
      end
      default: begin
        mode_nxt = MODE_IDLE; used = 1'b0;
      end
    endcase

    // Start a new token with this byte.
    if (!used && !is_space(text_byte)) begin
      priority if (is_alpha(text_byte) || text_byte == "_") begin
        mode_nxt = MODE_WORD; start_nxt = pos_r; len_nxt = OFFSET_BITS'(1);
        prefix_nxt = 64'(text_byte);
      end else if (is_digit(text_byte)) begin
        mode_nxt = MODE_INT; start_nxt = pos_r; len_nxt = OFFSET_BITS'(1);
      end else if (is_quote(text_byte)) begin
        mode_nxt = MODE_STR; quote_single_nxt = (text_byte == 8'h27);
        start_nxt = sat_inc(pos_r); len_nxt = '0;
      end else if (sc[6]) begin
        if (may_pair(text_byte)) begin
          mode_nxt = MODE_SYM; pend_nxt = text_byte; start_nxt = pos_r;
        end else begin
          tb = mk(KIND_SYMBOL, pos_r, OFFSET_BITS'(1), sc[5:0]); vb = 1'b1;
        end
      end else begin
        tb = mk(KIND_ERROR, pos_r, OFFSET_BITS'(1), 6'd0); vb = 1'b1;
        mode_nxt = MODE_DEAD;
      end
    end

    // End of text flushes whatever is still open.
    if (end_of_text) begin
      unique case (mode_nxt)
        MODE_WORD: begin tc = word_tok(prefix_nxt, len_nxt, start_nxt); vc = 1'b1; end
        MODE_INT:  begin tc = mk(KIND_INT, start_nxt, len_nxt, 6'd0); vc = 1'b1; end
        MODE_REAL: begin tc = mk(KIND_REAL, start_nxt, len_nxt, 6'd0); vc = 1'b1; end
        MODE_STR:  begin tc = mk(KIND_STRING, start_nxt, len_nxt, 6'd0); vc = 1'b1; end
        MODE_SYM: begin
          tc = mk(KIND_SYMBOL, start_nxt, OFFSET_BITS'(1), 6'(single_code(pend_nxt)));
          vc = 1'b1;
        end
        default: ;
      endcase
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      len_nxt    = '0;
      prefix_nxt = '0;
      pend_nxt   = '0;
    end else begin
      pos_nxt = sat_inc(pos_r);
    end

    // At most two tokens per byte, in order.
    push = '0;
    if (va) begin
      push.valid0 = 1'b1; push.tok0 = ta;
      if (vb) begin push.valid1 = 1'b1; push.tok1 = tb; end
      else if (vc) begin push.valid1 = 1'b1; push.tok1 = tc; end
    end else if (vb) begin
      push.valid0 = 1'b1; push.tok0 = tb;
      if (vc) begin push.valid1 = 1'b1; push.tok1 = tc; end
    end else if (vc) begin
      push.valid0 = 1'b1; push.tok0 = tc;
    end
    if (push.valid1) push.tok1.last = 1'b1;
    else if (push.valid0) push.tok0.last = 1'b1;
    if (!accept) begin
      push.valid0 = 1'b0;
      push.valid1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      quote_single_r <= 1'b0;
      pos_r          <= '0;
      start_r        <= '0;
      len_r          <= '0;
      prefix_r       <= '0;
      pend_r         <= '0;
    end else if (accept) begin
      mode_r         <= mode_nxt;
      quote_single_r <= quote_single_nxt;
      pos_r          <= pos_nxt;
      start_r        <= start_nxt;
      len_r          <= len_nxt;
      prefix_r       <= prefix_nxt;
      pend_r         <= pend_nxt;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid1 |-> push.valid0) else $error("second token without first");
  a_dead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DEAD && accept) |-> !push.valid0) else $error("token after error");
  a_eot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_text) |=> (mode_r == MODE_IDLE && pos_r == '0))
    else $error("end of text did not return to idle");

endmodule

@@ hw/rtl/stl_token_queue.sv @@
// Token queue between the lexer front part and the result channel.
module stl_token_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  stl_pkg::push_t push,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output stl_pkg::tok_t  out_tok
);
  import stl_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  tok_t            mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            pop;
  logic [1:0]      npush;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // Room for two tokens is needed before a byte may enter.
  assign full      = (cnt_r > (PW+1)'(QUEUE_DEPTH - 2));
  assign npush     = 2'(push.valid0) + 2'(push.valid1);
  assign cnt_nxt   = cnt_r + (PW+1)'(npush) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.valid0) mem_r[wr_r] <= push.tok0;
    if (push.valid1) mem_r[wr_r + 1'b1] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PW'(npush);
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(QUEUE_DEPTH)) else $error("token queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid0 |-> !full) else $error("push into full queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!push.valid0 && !pop) |=> $stable(cnt_r)) else $error("count moved while idle");

endmodule
